[sv/bfsk_pkg.sv]
// Shared constants for the binary FSK tone generator.
package bfsk_pkg;

    // Default sizes
    localparam int PATTERN_BITS_DEF   = 48;
    localparam int TABLE_LEN_ZERO_DEF = 48;
    localparam int TABLE_LEN_ONE_DEF  = 45;
    localparam int SAMPLE_BITS_DEF    = 12;

    // Field widths
    localparam int PATTERN_W  = 48;
    localparam int PERIODS_W  = 6;
    localparam int POSITION_W = 6;
    localparam int INDEX_W    = 6;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PATTERN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIODS_FOR_ZERO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIODS_FOR_ONE  = 2'd2;

    // Configuration reset values ("Hello", LSB first)
    localparam logic [PATTERN_W-1:0] RST_BIT_PATTERN      = 48'd478560413000;
    localparam logic [PERIODS_W-1:0] RST_PERIODS_FOR_ZERO = 6'd30;
    localparam logic [PERIODS_W-1:0] RST_PERIODS_FOR_ONE  = 6'd32;

    // Fixed-point sine constants, Q30
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] SIN_D1      = 64'd156;
    localparam logic [63:0] SIN_D2      = 64'd110;
    localparam logic [63:0] SIN_D3      = 64'd72;
    localparam logic [63:0] SIN_D4      = 64'd42;
    localparam logic [63:0] SIN_D5      = 64'd20;
    localparam logic [63:0] SIN_D6      = 64'd6;

endpackage

[sv/bfsk_sine_rom.sv]
// Sine lookup table of LEN entries, contents built at elaboration.
module bfsk_sine_rom #(
    parameter int LEN         = bfsk_pkg::TABLE_LEN_ZERO_DEF,
    parameter int SAMPLE_BITS = bfsk_pkg::SAMPLE_BITS_DEF,
    parameter int IDX_BITS    = $clog2(LEN)
) (
    input  logic [IDX_BITS-1:0]    i_index,
    output logic [SAMPLE_BITS-1:0] o_sample
);

    localparam logic [63:0] N   = 64'(LEN);
    localparam logic [63:0] AMP = (64'd1 << SAMPLE_BITS) - 64'd1;

    logic [SAMPLE_BITS-1:0] rom [LEN];

    for (genvar i = 0; i < LEN; i++) begin : g_entry
        // Fold the angle into the first quadrant, remember the sign
        localparam logic [63:0] U0  = 64'(i) * 64'd4;
        localparam bit          NEG = (U0 > 2 * N);
        localparam logic [63:0] U1  = NEG ? (U0 - 2 * N) : U0;
        localparam logic [63:0] U2  = (U1 > N) ? (2 * N - U1) : U1;
        // Taylor series in Horner form
        localparam logic [63:0] X   = (bfsk_pkg::HALF_PI_Q30 * U2) / N;
        localparam logic [63:0] X2  = (X * X) >> 30;
        localparam logic [63:0] R1  = bfsk_pkg::Q30_ONE
                                      - (((X2 * bfsk_pkg::Q30_ONE) >> 30) / bfsk_pkg::SIN_D1);
        localparam logic [63:0] R2  = bfsk_pkg::Q30_ONE - (((X2 * R1) >> 30) / bfsk_pkg::SIN_D2);
        localparam logic [63:0] R3  = bfsk_pkg::Q30_ONE - (((X2 * R2) >> 30) / bfsk_pkg::SIN_D3);
        localparam logic [63:0] R4  = bfsk_pkg::Q30_ONE - (((X2 * R3) >> 30) / bfsk_pkg::SIN_D4);
        localparam logic [63:0] R5  = bfsk_pkg::Q30_ONE - (((X2 * R4) >> 30) / bfsk_pkg::SIN_D5);
        localparam logic [63:0] R6  = bfsk_pkg::Q30_ONE - (((X2 * R5) >> 30) / bfsk_pkg::SIN_D6);
        localparam logic [63:0] S0  = (X * R6) >> 30;
        localparam logic [63:0] S1  = (S0 > bfsk_pkg::Q30_ONE) ? bfsk_pkg::Q30_ONE : S0;
        localparam logic [63:0] S   = (U2 == 64'd0) ? 64'd0 :
                                      (U2 == N) ? bfsk_pkg::Q30_ONE : S1;
        localparam logic [63:0] ENTRY = NEG ? ((AMP * (bfsk_pkg::Q30_ONE - S)) >> 31)
                                            : ((AMP * (bfsk_pkg::Q30_ONE + S)) >> 31);
        assign rom[i] = ENTRY[SAMPLE_BITS-1:0];
    end

    assign o_sample = rom[i_index];

endmodule

[sv/binary_fsk_tone_generator.sv]
// Binary FSK tone generator top level: sequencing, configuration and result register.
//
// One word in, one word out. Each accepted word (tick) yields one sample from the
// active sine table (tone zero: TABLE_LEN_ZERO entries, tone one: TABLE_LEN_ONE
// entries), and the result appears in the output register on the cycle after
// acceptance. A word can be accepted every cycle while the output register is empty or
// is being emptied: the table read and the index, period and bit-position updates
// are combinational and the new state is registered on acceptance. The sine tables are
// constant logic built at elaboration. Tick low re-reads the current sample without
// advancing. After periods_for_zero or periods_for_one full table periods (0 acts as
// 1) the position steps circularly through the low PATTERN_BITS bits of bit_pattern,
// and the new bit selects the tone, which always restarts at table entry 0.
// Write configuration only while no words are in flight.
module binary_fsk_tone_generator #(
    parameter int PATTERN_BITS   = bfsk_pkg::PATTERN_BITS_DEF,
    parameter int TABLE_LEN_ZERO = bfsk_pkg::TABLE_LEN_ZERO_DEF,
    parameter int TABLE_LEN_ONE  = bfsk_pkg::TABLE_LEN_ONE_DEF,
    parameter int SAMPLE_BITS    = bfsk_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [bfsk_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bfsk_pkg::PATTERN_W-1:0]      i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_tick,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [SAMPLE_BITS-1:0]              o_sample,
    output logic                                o_tone,
    output logic [bfsk_pkg::POSITION_W-1:0]     o_pattern_position,
    output logic                                o_period_flag,
    output logic                                o_bit_done
);

    localparam int ZERO_IDX_BITS = $clog2(TABLE_LEN_ZERO);
    localparam int ONE_IDX_BITS  = $clog2(TABLE_LEN_ONE);
    localparam int IW            = bfsk_pkg::INDEX_W;
    localparam int PW            = bfsk_pkg::POSITION_W;
    localparam logic [IW:0]   LEN_ZERO  = (IW + 1)'(TABLE_LEN_ZERO);
    localparam logic [IW:0]   LEN_ONE   = (IW + 1)'(TABLE_LEN_ONE);
    localparam logic [PW-1:0] LAST_POS  = PW'(PATTERN_BITS - 1);

    // configuration registers
    logic [bfsk_pkg::PATTERN_W-1:0] r_bit_pattern;
    logic [bfsk_pkg::PERIODS_W-1:0] r_periods_zero;
    logic [bfsk_pkg::PERIODS_W-1:0] r_periods_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_pattern  <= bfsk_pkg::RST_BIT_PATTERN;
            r_periods_zero <= bfsk_pkg::RST_PERIODS_FOR_ZERO;
            r_periods_one  <= bfsk_pkg::RST_PERIODS_FOR_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bfsk_pkg::CFG_BIT_PATTERN:      r_bit_pattern  <= i_cfg_data;
                bfsk_pkg::CFG_PERIODS_FOR_ZERO: r_periods_zero <= i_cfg_data[bfsk_pkg::PERIODS_W-1:0];
                bfsk_pkg::CFG_PERIODS_FOR_ONE:  r_periods_one  <= i_cfg_data[bfsk_pkg::PERIODS_W-1:0];
                default: ;
            endcase
        end
    end

    // generator state
    logic [IW-1:0]                  r_sample_index, n_sample_index;
    logic [bfsk_pkg::PERIODS_W-1:0] r_period_count, n_period_count;
    logic [PW-1:0]                  r_bit_position, n_bit_position;
    logic                           r_active_tone, n_active_tone;
    logic                           r_toggle_level, n_toggle_level;

    // result register
    logic                           r_out_valid;
    logic [SAMPLE_BITS-1:0]         r_sample;
    logic                           r_tone;
    logic [PW-1:0]                  r_position;
    logic                           r_flag;
    logic                           r_done;

    logic                           accept;
    logic [IW:0]                    len;
    logic [IW-1:0]                  idx;
    logic [IW:0]                    next_index;
    logic [bfsk_pkg::PERIODS_W-1:0] need;
    logic [bfsk_pkg::PERIODS_W-1:0] count_inc;
    logic [PW-1:0]                  pos_inc;
    logic                           done;
    logic [SAMPLE_BITS-1:0]         sample_zero;
    logic [SAMPLE_BITS-1:0]         sample_one;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign len = r_active_tone ? LEN_ONE : LEN_ZERO;
    // out-of-range index reads entry 0
    assign idx = ({1'b0, r_sample_index} < len) ? r_sample_index : '0;

    bfsk_sine_rom #(
        .LEN         (TABLE_LEN_ZERO),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_BITS    (ZERO_IDX_BITS)
    ) u_rom_zero (
        .i_index  (idx[ZERO_IDX_BITS-1:0]),
        .o_sample (sample_zero)
    );

    bfsk_sine_rom #(
        .LEN         (TABLE_LEN_ONE),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_BITS    (ONE_IDX_BITS)
    ) u_rom_one (
        .i_index  (idx[ONE_IDX_BITS-1:0]),
        .o_sample (sample_one)
    );

    assign next_index = {1'b0, r_sample_index} + (IW + 1)'(1);
    assign need       = r_active_tone ? r_periods_one : r_periods_zero;
    assign count_inc  = r_period_count + bfsk_pkg::PERIODS_W'(1);
    assign pos_inc    = (r_bit_position >= LAST_POS) ? '0 : r_bit_position + PW'(1);

    always_comb begin
        n_sample_index = r_sample_index;
        n_period_count = r_period_count;
        n_bit_position = r_bit_position;
        n_active_tone  = r_active_tone;
        n_toggle_level = r_toggle_level;
        done           = 1'b0;
        if (i_tick) begin
            if (next_index >= len) begin
                // end of a table period
                n_sample_index = '0;
                n_toggle_level = !r_toggle_level;
                n_period_count = count_inc;
                if (count_inc >= need) begin
                    n_bit_position = pos_inc;
                    n_period_count = '0;
                    n_active_tone  = r_bit_pattern[pos_inc];
                    done           = 1'b1;
                end
            end else begin
                n_sample_index = next_index[IW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_index <= '0;
            r_period_count <= '0;
            r_bit_position <= '0;
            r_active_tone  <= 1'b0;
            r_toggle_level <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_sample_index <= n_sample_index;
                r_period_count <= n_period_count;
                r_bit_position <= n_bit_position;
                r_active_tone  <= n_active_tone;
                r_toggle_level <= n_toggle_level;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample   <= r_active_tone ? sample_one : sample_zero;
            r_tone     <= r_active_tone;
            r_position <= r_bit_position;
            r_flag     <= n_toggle_level;
            r_done     <= done;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_sample           = r_sample;
    assign o_tone             = r_tone;
    assign o_pattern_position = r_position;
    assign o_period_flag      = r_flag;
    assign o_bit_done         = r_done;

endmodule
